// File: rtl/ita_pkg.sv
`default_nettype none

package ita_pkg;

    // width of the value field and of the packed input stream data
    localparam int VALUE_W    = 64;
    localparam int MODE_W     = 2;
    localparam int S_TDATA_W  = 72;
    localparam int CHAR_W     = 8;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HEX_ALT  = 2'd3;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_ZERO,
        ST_X,
        ST_DIGIT
    } ita_state_t;

    typedef enum logic [1:0] {
        SEL_SIGN,
        SEL_ZERO,
        SEL_X,
        SEL_DIGIT
    } ita_sel_t;

    typedef struct packed {
        logic     load;
        logic     conv_step;
        logic     find;
        logic     emit;
        ita_sel_t sel;
    } ita_cmd_t;

    typedef struct packed {
        logic hex;
        logic neg;
        logic conv_last;
        logic idx_zero;
    } ita_status_t;

    // one digit 0..15 to its lower-case ascii glyph
    function automatic logic [CHAR_W-1:0] ita_glyph(input logic [3:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {4'h0, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + dx;
        end
        return CHAR_LOW_A + dx - DIGIT_TEN;
    endfunction

endpackage

`default_nettype wire

// File: rtl/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: formats one integer as ascii text
//
// input channel s_*: one item holds a mode and a value. mode 0 prints
// unsigned decimal, mode 1 signed decimal ('-' if negative), modes 2 and 3
// print "0x" and lower-case hex. only the low VALUE_BITS bits of the value
// are used. leading zeros are dropped, zero prints as one '0' digit.
// output channel m_*: one item per character, most significant first,
// with tlast on the final character of the text.
// sequence: a decimal item is taken, passes through the binary to bcd unit
// (four shift-and-add-3 steps a cycle), has its top digit located, then
// is sent one character per cycle while the receiver is ready. a hex item
// skips the bcd unit.
// the next item is taken as soon as the last character sits in the output
// register, while that character still waits to be read.
// reset clears the controller and the output valid; no text is in flight.
// a stalled receiver holds the current character and the block waits.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [1:0] mode, [65:2] value, [71:66] zero
    input  wire logic [ita_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] char_code
    output logic [ita_pkg::CHAR_W-1:0]            m_tdata,
    output logic                                  m_tlast
);
    import ita_pkg::*;

    ita_cmd_t    cmd;
    ita_status_t status;

    // controller: handshakes and character sequencing
    ita_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: magnitude, bcd conversion, digit select, output register
    ita_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_mode  (s_tdata[MODE_W-1:0]),
        .in_value (s_tdata[MODE_W +: VALUE_W]),
        .status   (status),
        .out_char (m_tdata),
        .out_last (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/ita_dp.sv
`default_nettype none

module ita_dp #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ita_pkg::ita_cmd_t              cmd,
    input  wire logic [ita_pkg::MODE_W-1:0]     in_mode,
    input  wire logic [ita_pkg::VALUE_W-1:0]    in_value,
    output ita_pkg::ita_status_t                status,
    output logic [ita_pkg::CHAR_W-1:0]          out_char,
    output logic                                out_last
);
    import ita_pkg::*;

    localparam int PAD_BITS   = ((VALUE_BITS + 3) / 4) * 4;
    localparam int ITERS      = PAD_BITS / 4;
    localparam int HEX_DIGITS = PAD_BITS / 4;
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(ITERS);

    logic [PAD_BITS-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 hex_reg, hex_next;
    logic                 neg_reg, neg_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] in_v, in_mag;
    logic [PAD_BITS-1:0]   in_pad;
    logic                  in_neg, in_hex;
    logic [BCD_W-1:0]      dab_bcd;
    logic [PAD_BITS-1:0]   dab_bin;
    logic [IDX_W-1:0]      find_idx;
    logic [3:0]            cur_digit;
    logic [CHAR_W-1:0]     emit_char;
    logic                  emit_digit;

    // magnitude and mode decode of the incoming item
    always_comb begin
        in_v   = in_value[VALUE_BITS-1:0];
        in_hex = (in_mode == MODE_HEX) || (in_mode == MODE_HEX_ALT);
        in_neg = (in_mode == MODE_SIGNED) && in_v[VALUE_BITS-1];
        in_mag = in_neg ? ((~in_v) + VALUE_BITS'(1)) : in_v;
        in_pad = PAD_BITS'(in_mag);
    end

    // four shift-and-add-3 steps per cycle
    always_comb begin
        logic [BCD_W+PAD_BITS-1:0] work;
        work = {bcd_reg, bin_reg};
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (work[PAD_BITS + 4*d +: 4] >= 4'd5) begin
                    work[PAD_BITS + 4*d +: 4] = work[PAD_BITS + 4*d +: 4] + 4'd3;
                end
            end
            work = work << 1;
        end
        dab_bcd = work[BCD_W+PAD_BITS-1:PAD_BITS];
        dab_bin = work[PAD_BITS-1:0];
    end

    // most significant non-zero digit, zero if none
    always_comb begin
        find_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] != 4'd0) begin
                find_idx = IDX_W'(d);
            end
        end
    end

    always_comb begin
        cur_digit  = bcd_reg[{idx_reg, 2'b00} +: 4];
        emit_digit = cmd.emit && (cmd.sel == SEL_DIGIT);
        case (cmd.sel)
            SEL_SIGN:  emit_char = CHAR_MINUS;
            SEL_ZERO:  emit_char = CHAR_ZERO;
            SEL_X:     emit_char = CHAR_X;
            SEL_DIGIT: emit_char = ita_glyph(cur_digit);
            default:   emit_char = CHAR_ZERO;
        endcase
    end

    always_comb begin
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        hex_next      = hex_reg;
        neg_next      = neg_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        if (cmd.load) begin
            hex_next = in_hex;
            neg_next = in_neg;
            cnt_next = '0;
            // hex digits are the nibbles themselves
            bin_next = in_hex ? '0 : in_pad;
            bcd_next = in_hex ? BCD_W'(in_pad) : '0;
        end
        if (cmd.conv_step) begin
            bin_next = dab_bin;
            bcd_next = dab_bcd;
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.find) begin
            idx_next = find_idx;
        end
        if (cmd.emit) begin
            out_char_next = emit_char;
            out_last_next = emit_digit && (idx_reg == '0);
        end
        if (emit_digit && (idx_reg != '0)) begin
            idx_next = idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        hex_reg      <= hex_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign status.hex       = hex_reg;
    assign status.neg       = neg_reg;
    assign status.conv_last = (cnt_reg == CNT_W'(ITERS - 1));
    assign status.idx_zero  = (idx_reg == '0);
    assign out_char         = out_char_reg;
    assign out_last         = out_last_reg;

    a_last_on_final_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (cmd.sel == SEL_DIGIT) && (idx_reg == '0)) |=> out_last_reg)
        else $error("final digit not marked last");

    a_prefix_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (cmd.sel != SEL_DIGIT)) |=> !out_last_reg)
        else $error("prefix character marked last");

    a_load_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cnt_reg == '0))
        else $error("iteration count not cleared on load");

endmodule

`default_nettype wire

// File: rtl/ita_ctrl.sv
`default_nettype none

module ita_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    input  wire ita_pkg::ita_status_t status,
    output ita_pkg::ita_cmd_t         cmd
);
    import ita_pkg::*;

    ita_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (status.hex || status.conv_last) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                if (status.hex) begin
                    state_next = ST_ZERO;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    state_next = ST_X;
                end
            end
            ST_X: begin
                if (out_free) begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free && status.idx_zero) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.find      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_DIGIT;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONV: begin
                cmd.conv_step = !status.hex;
            end
            ST_FIND: begin
                cmd.find = 1'b1;
            end
            ST_SIGN: begin
                cmd.emit = out_free;
                cmd.sel  = SEL_SIGN;
            end
            ST_ZERO: begin
                cmd.emit = out_free;
                cmd.sel  = SEL_ZERO;
            end
            ST_X: begin
                cmd.emit = out_free;
                cmd.sel  = SEL_X;
            end
            ST_DIGIT: begin
                cmd.emit = out_free;
                cmd.sel  = SEL_DIGIT;
            end
            default: begin
                cmd.sel = SEL_DIGIT;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_starts_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> (state_reg == ST_CONV))
        else $error("accepted item did not start conversion");

    a_stall_holds_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DIGIT))
        else $error("digit phase left while output stalled");

    a_hex_skips_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && status.hex) |=> (state_reg == ST_FIND))
        else $error("hex item ran decimal conversion");

endmodule

`default_nettype wire
